### design/itgdt_pkg.sv
// Shared types and constants of the grouped decimal text formatter.
package itgdt_pkg;

   localparam int NUM_BCD = 20;
   localparam int BCD_BITS = 4 * NUM_BCD;
   localparam logic [5:0] MAX_WIDTH = 6'd62;
   localparam logic [7:0] CHAR_ZERO = 8'd48;

   localparam logic [2:0] REG_MIN_WIDTH  = 3'd0;
   localparam logic [2:0] REG_GROUP_SIZE = 3'd1;
   localparam logic [2:0] REG_FILL       = 3'd2;
   localparam logic [2:0] REG_DELIMITER  = 3'd3;
   localparam logic [2:0] REG_POS_PREFIX = 3'd4;
   localparam logic [2:0] REG_NEG_PREFIX = 3'd5;
   localparam logic [2:0] REG_POS_SUFFIX = 3'd6;
   localparam logic [2:0] REG_NEG_SUFFIX = 3'd7;

   typedef struct packed {
      logic [63:0] mag;
      logic        neg;
      logic        pos;
   } item_type;

   typedef struct packed {
      logic [5:0] min_width;
      logic [4:0] group_size;
      logic [7:0] fill_char;
      logic [7:0] delimiter_char;
      logic [7:0] pos_prefix_char;
      logic [7:0] neg_prefix_char;
      logic [7:0] pos_suffix_char;
      logic [7:0] neg_suffix_char;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      min_width: 6'd0, group_size: 5'd0, fill_char: 8'd32, delimiter_char: 8'd32,
      pos_prefix_char: 8'd0, neg_prefix_char: 8'd45,
      pos_suffix_char: 8'd0, neg_suffix_char: 8'd0};

endpackage

### design/itgdt_front.sv
// Front end: takes a number, splits sign and magnitude, and queues the word.
module itgdt_front import itgdt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] number,
   output logic        busy,
   output item_type    head,
   output logic        head_valid,
   input  logic        pop
);

   item_type   queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   item;

   assign busy = (count_ff == 2'd2);
   assign push = start && !busy;

   always_comb begin
      item.neg = number[63];
      item.pos = !number[63] && (number != 64'd0);
      item.mag = number[63] ? (~number + 64'd1) : number;
   end

   assign head       = queue_ff[rd_ptr_ff];
   assign head_valid = (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

### design/itgdt_back.sv
// Back end: binary to BCD conversion, grouping count and character emission.
module itgdt_back import itgdt_pkg::*; #(
   parameter int MAX_DIGITS = 20
) (
   input  logic       clock,
   input  logic       reset,
   input  item_type   head,
   input  logic       head_valid,
   output logic       pop,
   input  cfg_type    cfg,
   output logic       rsp_strobe,
   output logic [7:0] rsp_out_char,
   output logic       rsp_is_last
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_LEN  = 3'd2;
   localparam logic [2:0] ST_GRP  = 3'd3;
   localparam logic [2:0] ST_PRE  = 3'd4;
   localparam logic [2:0] ST_FILL = 3'd5;
   localparam logic [2:0] ST_DIG  = 3'd6;
   localparam logic [2:0] ST_SUF  = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [BCD_BITS-1:0] bcd_ff, bcd_in;
   logic [63:0]         shreg_ff, shreg_in;
   logic [5:0]          bit_cnt_ff, bit_cnt_in;
   logic                neg_ff, neg_in, pos_ff, pos_in;
   logic [4:0]          len_ff, len_in;
   logic [4:0]          rem_ff, rem_in;
   logic [4:0]          spcnt_ff, spcnt_in;
   logic [5:0]          fill_cnt_ff, fill_cnt_in;
   logic [4:0]          idx_ff, idx_in;
   logic [4:0]          grp_ff, grp_in;
   logic                delim_ff, delim_in;
   logic                strobe_ff, strobe_in;
   logic [7:0]          char_ff, char_in;
   logic                last_ff, last_in;

   logic [BCD_BITS-1:0] bcd_adj;
   logic [4:0]          ndig;
   logic [5:0]          width;
   logic [5:0]          flen;
   logic [7:0]          prefix_c, suffix_c;
   logic [3:0]          cur_digit;

   // Add three to every digit of five or more before the shift.
   always_comb begin
      bcd_adj = bcd_ff;
      for (int d = 0; d < NUM_BCD; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end
      end
   end

   always_comb begin
      ndig = 5'd1;
      for (int d = 0; d < NUM_BCD; d++) begin
         if (bcd_ff[4*d +: 4] != 4'd0) begin
            ndig = 5'(d + 1);
         end
      end
   end

   always_comb begin
      width    = (cfg.min_width > MAX_WIDTH) ? MAX_WIDTH : cfg.min_width;
      flen     = {1'b0, len_ff} + {1'b0, spcnt_ff};
      prefix_c = neg_ff ? cfg.neg_prefix_char : (pos_ff ? cfg.pos_prefix_char : 8'd0);
      suffix_c = neg_ff ? cfg.neg_suffix_char : (pos_ff ? cfg.pos_suffix_char : 8'd0);
      cur_digit = bcd_ff[{idx_ff, 2'b00} +: 4];
   end

   always_comb begin
      state_in    = state_ff;
      bcd_in      = bcd_ff;
      shreg_in    = shreg_ff;
      bit_cnt_in  = bit_cnt_ff;
      neg_in      = neg_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      rem_in      = rem_ff;
      spcnt_in    = spcnt_ff;
      fill_cnt_in = fill_cnt_ff;
      idx_in      = idx_ff;
      grp_in      = grp_ff;
      delim_in    = delim_ff;
      strobe_in   = 1'b0;
      char_in     = char_ff;
      last_in     = 1'b0;
      pop         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop        = 1'b1;
               shreg_in   = head.mag;
               neg_in     = head.neg;
               pos_in     = head.pos;
               bcd_in     = '0;
               bit_cnt_in = 6'd0;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in     = {bcd_adj[BCD_BITS-2:0], shreg_ff[63]};
            shreg_in   = {shreg_ff[62:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 6'd1;
            if (bit_cnt_ff == 6'd63) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            len_in   = (ndig > 5'(MAX_DIGITS)) ? 5'(MAX_DIGITS) : ndig;
            rem_in   = len_in - 5'd1;
            spcnt_in = 5'd0;
            state_in = ST_GRP;
         end
         ST_GRP: begin
            // Repeated subtraction leaves the delimiter count and the size of the
            // leading group, less one.
            if (cfg.group_size != 5'd0 && rem_ff >= cfg.group_size) begin
               rem_in   = rem_ff - cfg.group_size;
               spcnt_in = spcnt_ff + 5'd1;
            end else begin
               fill_cnt_in = (width > flen) ? (width - flen) : 6'd0;
               idx_in      = len_ff - 5'd1;
               grp_in      = rem_ff;
               delim_in    = 1'b0;
               state_in    = ST_PRE;
            end
         end
         ST_PRE: begin
            strobe_in = (prefix_c != 8'd0);
            char_in   = prefix_c;
            state_in  = ST_FILL;
         end
         ST_FILL: begin
            if (fill_cnt_ff == 6'd0) begin
               state_in = ST_DIG;
            end else begin
               strobe_in   = (cfg.fill_char != 8'd0);
               char_in     = cfg.fill_char;
               fill_cnt_in = fill_cnt_ff - 6'd1;
            end
         end
         ST_DIG: begin
            if (delim_ff) begin
               strobe_in = (cfg.delimiter_char != 8'd0);
               char_in   = cfg.delimiter_char;
               delim_in  = 1'b0;
            end else begin
               strobe_in = 1'b1;
               char_in   = CHAR_ZERO + {4'd0, cur_digit};
               last_in   = (idx_ff == 5'd0) && (suffix_c == 8'd0);
               if (idx_ff == 5'd0) begin
                  state_in = ST_SUF;
               end else begin
                  idx_in = idx_ff - 5'd1;
                  if (grp_ff == 5'd0) begin
                     delim_in = 1'b1;
                     grp_in   = cfg.group_size - 5'd1;
                  end else begin
                     grp_in = grp_ff - 5'd1;
                  end
               end
            end
         end
         ST_SUF: begin
            strobe_in = (suffix_c != 8'd0);
            char_in   = suffix_c;
            last_in   = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff      <= bcd_in;
      shreg_ff    <= shreg_in;
      bit_cnt_ff  <= bit_cnt_in;
      neg_ff      <= neg_in;
      pos_ff      <= pos_in;
      len_ff      <= len_in;
      rem_ff      <= rem_in;
      spcnt_ff    <= spcnt_in;
      fill_cnt_ff <= fill_cnt_in;
      idx_ff      <= idx_in;
      grp_ff      <= grp_in;
      delim_ff    <= delim_in;
      char_ff     <= char_in;
      last_ff     <= last_in;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_out_char = char_ff;
   assign rsp_is_last  = strobe_ff && last_ff;

`ifndef SYNTHESIS
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_IDLE))
      else $error("queue popped outside idle");
   a_digit_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIG) |-> (idx_ff < 5'(NUM_BCD)))
      else $error("digit index out of range");
   a_last_ends_word: assert property (@(posedge clock) disable iff (reset)
      rsp_is_last |=> !rsp_strobe)
      else $error("character strobed right after the last one");
   a_strobed_char_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_out_char != 8'd0))
      else $error("empty character strobed");
`endif

endmodule

### design/int_to_grouped_decimal_text_top.sv
// Top level of the grouped decimal text formatter.
// Takes a signed 64-bit number on start (while busy is low) and emits its
// decimal text one character per strobe, with rsp_is_last on the final one.
// The receiver cannot stall, so every strobed character must be taken. A
// two-word queue stands in front of the formatter; each word goes through the
// one-bit-per-cycle BCD conversion, the digit count, the group count loop that
// counts the delimiters, then the prefix, the fill characters, the digits with
// their delimiters and the suffix.
module int_to_grouped_decimal_text_top import itgdt_pkg::*; #(
   parameter int MAX_DIGITS = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_number,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_is_last,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_write_data
);

   cfg_type  cfg_ff, cfg_in;
   item_type head;
   logic     head_valid;
   logic     pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_MIN_WIDTH:  cfg_in.min_width       = csr_write_data[5:0];
            REG_GROUP_SIZE: cfg_in.group_size      = csr_write_data[4:0];
            REG_FILL:       cfg_in.fill_char       = csr_write_data;
            REG_DELIMITER:  cfg_in.delimiter_char  = csr_write_data;
            REG_POS_PREFIX: cfg_in.pos_prefix_char = csr_write_data;
            REG_NEG_PREFIX: cfg_in.neg_prefix_char = csr_write_data;
            REG_POS_SUFFIX: cfg_in.pos_suffix_char = csr_write_data;
            REG_NEG_SUFFIX: cfg_in.neg_suffix_char = csr_write_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   itgdt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .number     (req_number),
      .busy       (busy),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop)
   );

   itgdt_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_valid   (head_valid),
      .pop          (pop),
      .cfg          (cfg_ff),
      .rsp_strobe   (rsp_strobe),
      .rsp_out_char (rsp_out_char),
      .rsp_is_last  (rsp_is_last)
   );

endmodule
